FILE: sv/fct_pkg.sv
// Shared types and constants for the flow counter hash table.
package fct_pkg;

    localparam int SET_BITS_DEF = 16;
    localparam int WAYS_DEF     = 7;
    localparam int VLAN_W       = 12;

    localparam logic [1:0] CMD_COUNT = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [11:0] vlan_id;
        logic [15:0] packet_length;
        logic [15:0] read_set;
        logic [2:0]  read_way;
    } t_item;

    typedef struct packed {
        logic        src_dropped;
        logic        dst_dropped;
        logic        entry_valid;
        logic [31:0] entry_ip;
        logic [11:0] entry_vlan;
        logic [31:0] packets_in_count;
        logic [31:0] packets_out_count;
        logic [63:0] bytes_in_count;
        logic [63:0] bytes_out_count;
    } t_result;

endpackage

FILE: sv/fct_mem.sv
// Used-flag row memory and entry memory of the flow counter table.
module fct_mem
    import fct_pkg::*;
#(
    parameter int SET_BITS = SET_BITS_DEF,
    parameter int WAYS     = WAYS_DEF,
    parameter int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1,
    parameter int ENT_W    = 32 - SET_BITS + VLAN_W + 192
) (
    input  logic                      i_clk,
    input  logic [SET_BITS-1:0]       i_used_raddr,
    output logic [WAYS-1:0]           o_used_rdata,
    input  logic                      i_used_we,
    input  logic [SET_BITS-1:0]       i_used_waddr,
    input  logic [WAYS-1:0]           i_used_wdata,
    input  logic [SET_BITS+WAY_W-1:0] i_ent_raddr,
    output logic [ENT_W-1:0]          o_ent_rdata,
    input  logic                      i_ent_we,
    input  logic [SET_BITS+WAY_W-1:0] i_ent_waddr,
    input  logic [ENT_W-1:0]          i_ent_wdata
);

    logic [WAYS-1:0]  r_used_mem [2**SET_BITS];
    logic [ENT_W-1:0] r_ent_mem  [2**(SET_BITS+WAY_W)];

    always_ff @(posedge i_clk) begin
        if (i_used_we) begin
            r_used_mem[i_used_waddr] <= i_used_wdata;
        end
        o_used_rdata <= r_used_mem[i_used_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ent_we) begin
            r_ent_mem[i_ent_waddr] <= i_ent_wdata;
        end
        o_ent_rdata <= r_ent_mem[i_ent_raddr];
    end

endmodule

FILE: sv/flow_counter_hash_table.sv
// Top level of the set-associative flow counter table.
// One command at a time; busy is high while it runs. A count takes a read and a compare
// state per way searched for the source and for the destination, then a result state. A
// read takes read, compare and result states. A clear, and the pass after reset, sweep
// the used-flag memory one set per cycle; a clear command then gets a result state.
// Each result is on o_result for one cycle with o_done high and cannot be held off.
module flow_counter_hash_table
    import fct_pkg::*;
#(
    parameter int SET_BITS = SET_BITS_DEF,
    parameter int WAYS     = WAYS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_done,
    output t_result o_result
);

    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int HIGH_W = 32 - SET_BITS;
    localparam int KEY_W  = HIGH_W + VLAN_W;
    localparam int ENT_W  = KEY_W + 192;

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_RD, S_CMP, S_RCMP, S_OUT
    } t_state;

    t_state               r_state, n_state;
    logic                 r_clr_cmd, n_clr_cmd;
    logic [SET_BITS-1:0]  r_clr, n_clr;
    logic                 r_is_read, n_is_read;
    logic                 r_phase, n_phase;
    logic                 r_rok, n_rok;
    logic [SET_BITS-1:0]  r_set, n_set;
    logic [WAY_W-1:0]     r_way, n_way;
    logic [KEY_W-1:0]     r_key, n_key;
    logic [SET_BITS-1:0]  r_dset, n_dset;
    logic [KEY_W-1:0]     r_dkey, n_dkey;
    logic [15:0]          r_len, n_len;
    t_result              r_res, n_res;

    logic [WAYS-1:0]      used_q;
    logic [ENT_W-1:0]     ent_q;
    logic                 used_we;
    logic [SET_BITS-1:0]  used_waddr;
    logic [WAYS-1:0]      used_wdata;
    logic                 ent_we;
    logic [ENT_W-1:0]     ent_wdata;

    logic                 cur_used;
    logic [KEY_W-1:0]     q_key;
    logic [31:0]          q_pin, q_pout;
    logic [63:0]          q_bin, q_bout;
    logic [31:0]          u_pin, u_pout;
    logic [63:0]          u_bin, u_bout;
    logic [63:0]          add_a, add_s;
    logic                 hit;

    fct_mem #(
        .SET_BITS(SET_BITS),
        .WAYS    (WAYS),
        .WAY_W   (WAY_W),
        .ENT_W   (ENT_W)
    ) u_mem (
        .i_clk       (i_clk),
        .i_used_raddr(r_set),
        .o_used_rdata(used_q),
        .i_used_we   (used_we),
        .i_used_waddr(used_waddr),
        .i_used_wdata(used_wdata),
        .i_ent_raddr ({r_set, r_way}),
        .o_ent_rdata (ent_q),
        .i_ent_we    (ent_we),
        .i_ent_waddr ({r_set, r_way}),
        .i_ent_wdata (ent_wdata)
    );

    assign cur_used = used_q[r_way];
    assign q_key    = ent_q[ENT_W-1:192];
    assign q_pin    = cur_used ? ent_q[191:160] : 32'd0;
    assign q_pout   = cur_used ? ent_q[159:128] : 32'd0;
    assign q_bin    = cur_used ? ent_q[127:64]  : 64'd0;
    assign q_bout   = cur_used ? ent_q[63:0]    : 64'd0;
    assign hit      = !cur_used || (q_key == r_key);

    always_comb begin
        add_a = r_phase ? q_bin : q_bout;
        add_s = add_a + {48'd0, r_len};
        u_pin  = q_pin;
        u_pout = q_pout;
        u_bin  = q_bin;
        u_bout = q_bout;
        if (r_phase) begin
            u_pin = q_pin + 32'd1;
            u_bin = add_s;
        end else begin
            u_pout = q_pout + 32'd1;
            u_bout = add_s;
        end
        ent_wdata = {r_key, u_pin, u_pout, u_bin, u_bout};
    end

    always_comb begin
        n_state   = r_state;
        n_clr_cmd = r_clr_cmd;
        n_clr     = r_clr;
        n_is_read = r_is_read;
        n_phase   = r_phase;
        n_rok     = r_rok;
        n_set     = r_set;
        n_way     = r_way;
        n_key     = r_key;
        n_dset    = r_dset;
        n_dkey    = r_dkey;
        n_len     = r_len;
        n_res     = r_res;
        used_we    = 1'b0;
        used_waddr = r_set;
        used_wdata = used_q | (WAYS'(1) << r_way);
        ent_we     = 1'b0;
        case (r_state)
            S_CLR: begin
                used_we    = 1'b1;
                used_waddr = r_clr;
                used_wdata = '0;
                n_clr      = r_clr + 1'b1;
                if (r_clr == {SET_BITS{1'b1}}) begin
                    n_state = r_clr_cmd ? S_OUT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_res   = '0;
                    n_way   = '0;
                    n_phase = 1'b0;
                    n_len   = i_item.packet_length;
                    case (i_item.command)
                        CMD_COUNT: begin
                            n_is_read = 1'b0;
                            n_set  = i_item.src_ip[SET_BITS-1:0];
                            n_key  = {i_item.src_ip[31:SET_BITS], i_item.vlan_id};
                            n_dset = i_item.dst_ip[SET_BITS-1:0];
                            n_dkey = {i_item.dst_ip[31:SET_BITS], i_item.vlan_id};
                            n_state = S_RD;
                        end
                        CMD_READ: begin
                            n_is_read = 1'b1;
                            n_set = SET_BITS'(i_item.read_set);
                            n_way = WAY_W'(i_item.read_way);
                            n_rok = (32'(i_item.read_way) < WAYS);
                            n_state = S_RD;
                        end
                        CMD_CLEAR: begin
                            n_clr_cmd = 1'b1;
                            n_clr     = '0;
                            n_state   = S_CLR;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = r_is_read ? S_RCMP : S_CMP;
            end
            S_CMP: begin
                if (hit || r_way == WAY_W'(WAYS - 1)) begin
                    if (hit) begin
                        used_we = 1'b1;
                        ent_we  = 1'b1;
                    end else if (r_phase) begin
                        n_res.dst_dropped = 1'b1;
                    end else begin
                        n_res.src_dropped = 1'b1;
                    end
                    if (r_phase) begin
                        n_state = S_OUT;
                    end else begin
                        n_phase = 1'b1;
                        n_set   = r_dset;
                        n_key   = r_dkey;
                        n_way   = '0;
                        n_state = S_RD;
                    end
                end else begin
                    n_way   = r_way + 1'b1;
                    n_state = S_RD;
                end
            end
            S_RCMP: begin
                if (r_rok && cur_used) begin
                    n_res.entry_valid       = 1'b1;
                    n_res.entry_ip          = {q_key[KEY_W-1:VLAN_W], r_set};
                    n_res.entry_vlan        = q_key[VLAN_W-1:0];
                    n_res.packets_in_count  = q_pin;
                    n_res.packets_out_count = q_pout;
                    n_res.bytes_in_count    = q_bin;
                    n_res.bytes_out_count   = q_bout;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_cmd <= 1'b0;
            r_clr     <= '0;
            r_is_read <= 1'b0;
            r_phase   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cmd <= (n_state == S_IDLE) ? 1'b0 : n_clr_cmd;
            r_clr     <= n_clr;
            r_is_read <= n_is_read;
            r_phase   <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rok  <= n_rok;
        r_set  <= n_set;
        r_way  <= n_way;
        r_key  <= n_key;
        r_dset <= n_dset;
        r_dkey <= n_dkey;
        r_len  <= n_len;
        r_res  <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = (r_state == S_OUT);
    assign o_result = r_res;

endmodule
